[src/rfd_pkg.sv]
`default_nettype none

package rfd_pkg;

  localparam int MAX_FIELDS_DEF        = 16;
  localparam int MAX_PAYLOAD_BYTES_DEF = 65536;

  localparam logic [7:0] LEN_VARIABLE = 8'h00;
  localparam logic [7:0] LEN_INVALID  = 8'hff;
  localparam int         PREFIX_BYTES = 4;

  localparam logic [7:0]  BEGIN_MARKER_RST = 8'd1;
  localparam logic [7:0]  END_MARKER_RST   = 8'd2;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_FIRST    = 3'd1,
    PH_ID       = 3'd2,
    PH_PREFIX   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_SKIP     = 3'd5,
    PH_BADBEGIN = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERR   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_BEGIN = 3'd1,
    ERR_BAD_LEN   = 3'd2,
    ERR_TRUNC     = 3'd3,
    ERR_EMPTY     = 3'd4,
    ERR_TOO_LONG  = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    REG_BEGIN_MARKER = 3'd0,
    REG_END_MARKER   = 3'd1,
    REG_FIELD_COUNT  = 3'd2,
    REG_LENGTHS_LOW  = 3'd3,
    REG_LENGTHS_HIGH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  begin_marker;
    logic [7:0]  end_marker;
    logic [4:0]  field_count;
    logic [63:0] lengths_low;
    logic [63:0] lengths_high;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field_id;
    logic [7:0]  payload_byte;
    logic        field_first;
    logic        field_last;
    logic [30:0] field_length;
    err_t        error_code;
  } result_t;

endpackage

`default_nettype wire

[src/record_field_deframer.sv]
// record_field_deframer
// Splits a byte stream of records into tagged payload words.
// Input channel: in_valid/in_ready with in_data_byte and in_buffer_last, one
// buffer byte per word; in_buffer_last marks the final byte of a buffer.
// Result channel: out_valid/out_ready with kind, field id, payload byte,
// first/last marks, field length and error code. A byte gives zero or one
// result word; id/prefix bytes give one only on error, end marker or empty field.
// Configuration: cfg_we/cfg_index/cfg_data write the markers, field count and
// packed length codes; write only while the block is idle.
// Throughput: one byte per cycle while in_ready is high; each byte updates the
// parse state in the cycle it is accepted.
// A result is written into the output buffer when its byte is accepted.
// A two-word output buffer separates the sides: input keeps flowing while one
// result waits, and in_ready drops only when both entries are held.
// Reset (rst_n low, synchronous) loads the default configuration, empties the
// output buffer and returns the parser to waiting for a begin marker.
`default_nettype none

module record_field_deframer #(
  parameter int MAX_FIELDS        = rfd_pkg::MAX_FIELDS_DEF,
  parameter int MAX_PAYLOAD_BYTES = rfd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_buffer_last,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_field_id,
  output logic [7:0]       out_payload_byte,
  output logic             out_field_first,
  output logic             out_field_last,
  output logic [30:0]      out_field_length,
  output logic [2:0]       out_error_code
);

  rfd_pkg::cfg_t    cfg_r;
  rfd_pkg::result_t core_res;
  rfd_pkg::result_t buf_res;
  logic             core_res_valid;
  logic             buf_full;
  logic             in_accept;

  assign in_ready  = !buf_full;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.begin_marker <= rfd_pkg::BEGIN_MARKER_RST;
      cfg_r.end_marker   <= rfd_pkg::END_MARKER_RST;
      cfg_r.field_count  <= '0;
      cfg_r.lengths_low  <= '0;
      cfg_r.lengths_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfd_pkg::REG_BEGIN_MARKER: cfg_r.begin_marker <= cfg_data[7:0];
        rfd_pkg::REG_END_MARKER:   cfg_r.end_marker   <= cfg_data[7:0];
        rfd_pkg::REG_FIELD_COUNT:  cfg_r.field_count  <= cfg_data[4:0];
        rfd_pkg::REG_LENGTHS_LOW:  cfg_r.lengths_low  <= cfg_data;
        rfd_pkg::REG_LENGTHS_HIGH: cfg_r.lengths_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rfd_core #(
    .MAX_FIELDS        (MAX_FIELDS),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step_en   (in_accept),
    .in_data   (in_data_byte),
    .in_last   (in_buffer_last),
    .res       (core_res),
    .res_valid (core_res_valid)
  );

  rfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && core_res_valid),
    .din       (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (buf_res)
  );

  assign out_kind         = buf_res.kind;
  assign out_field_id     = buf_res.field_id;
  assign out_payload_byte = buf_res.payload_byte;
  assign out_field_first  = buf_res.field_first;
  assign out_field_last   = buf_res.field_last;
  assign out_field_length = buf_res.field_length;
  assign out_error_code   = buf_res.error_code;

endmodule

`default_nettype wire

[src/rfd_core.sv]
`default_nettype none

module rfd_core #(
  parameter int MAX_FIELDS        = rfd_pkg::MAX_FIELDS_DEF,
  parameter int MAX_PAYLOAD_BYTES = rfd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rfd_pkg::cfg_t   cfg,
  input  wire logic            step_en,
  input  wire logic [7:0]      in_data,
  input  wire logic            in_last,
  output rfd_pkg::result_t     res,
  output logic                 res_valid
);

  localparam int TW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam logic [7:0]    MAX_FIELDS_B = 8'(MAX_FIELDS);
  localparam logic [TW:0]   MAX_FIX      = (TW + 1)'(MAX_PAYLOAD_BYTES);
  localparam logic [32:0]   MAX_VAR      = 33'(MAX_PAYLOAD_BYTES);
  localparam logic [1:0]    PREFIX_LAST  = 2'(rfd_pkg::PREFIX_BYTES - 1);

  rfd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      cur_field_r, cur_field_nxt;
  logic [30:0]     bytes_left_r, bytes_left_nxt;
  logic [1:0]      prefix_idx_r, prefix_idx_nxt;
  logic [31:0]     prefix_val_r, prefix_val_nxt;
  logic [TW-1:0]   total_r, total_nxt;

  logic            id_defined;
  logic [7:0]      len_code;
  logic [TW:0]     fix_sum;
  logic            fix_over;
  logic [31:0]     pv_new;
  logic [32:0]     var_sum;
  logic            var_over;
  logic [30:0]     bl_dec;

  logic            do_take;
  logic            fin;
  rfd_pkg::kind_t  fin_kind;
  rfd_pkg::err_t   fin_code;

  assign id_defined = (in_data < {3'b000, cfg.field_count}) && (in_data < MAX_FIELDS_B)
                   && (in_data < 8'd16);
  assign len_code   = in_data[3] ? cfg.lengths_high[8*in_data[2:0] +: 8]
                                 : cfg.lengths_low[8*in_data[2:0] +: 8];
  assign fix_sum    = {1'b0, total_r} + (TW + 1)'(len_code);
  assign fix_over   = fix_sum > MAX_FIX;
  assign pv_new     = prefix_val_r | ({24'b0, in_data} << {prefix_idx_r, 3'b000});
  assign var_sum    = (33)'(total_r) + {1'b0, pv_new};
  assign var_over   = pv_new[31] || (var_sum > MAX_VAR);
  assign bl_dec     = bytes_left_r - 31'd1;

  always_comb begin
    phase_nxt      = phase_r;
    cur_field_nxt  = cur_field_r;
    bytes_left_nxt = bytes_left_r;
    prefix_idx_nxt = prefix_idx_r;
    prefix_val_nxt = prefix_val_r;
    total_nxt      = total_r;
    res_valid      = 1'b0;
    res            = '0;
    do_take        = 1'b0;
    fin            = 1'b0;
    fin_kind       = rfd_pkg::KIND_ERR;
    fin_code       = rfd_pkg::ERR_NONE;

    case (phase_r)
      rfd_pkg::PH_FIRST, rfd_pkg::PH_BADBEGIN: begin
        if (in_last) begin
          fin      = 1'b1;
          fin_code = rfd_pkg::ERR_EMPTY;
        end else if (phase_r == rfd_pkg::PH_BADBEGIN) begin
          fin      = 1'b1;
          fin_code = rfd_pkg::ERR_BAD_BEGIN;
        end else begin
          do_take = 1'b1;
        end
      end
      rfd_pkg::PH_ID: begin
        do_take = 1'b1;
      end
      rfd_pkg::PH_PREFIX: begin
        prefix_val_nxt = pv_new;
        if (in_last) begin
          fin      = 1'b1;
          fin_code = rfd_pkg::ERR_TRUNC;
        end else if (prefix_idx_r != PREFIX_LAST) begin
          prefix_idx_nxt = prefix_idx_r + 2'd1;
        end else begin
          prefix_idx_nxt = '0;
          if (var_over) begin
            fin      = 1'b1;
            fin_code = rfd_pkg::ERR_TOO_LONG;
          end else if (pv_new == 32'd0) begin
            phase_nxt    = rfd_pkg::PH_ID;
            res_valid    = 1'b1;
            res.kind     = rfd_pkg::KIND_EMPTY;
            res.field_id = cur_field_r;
          end else begin
            bytes_left_nxt = pv_new[30:0];
            total_nxt      = total_r + pv_new[TW-1:0];
            phase_nxt      = rfd_pkg::PH_PAYLOAD;
          end
        end
      end
      rfd_pkg::PH_PAYLOAD: begin
        if (in_last) begin
          fin      = 1'b1;
          fin_code = rfd_pkg::ERR_TRUNC;
        end else begin
          res_valid        = 1'b1;
          res.kind         = rfd_pkg::KIND_DATA;
          res.field_id     = cur_field_r;
          res.payload_byte = in_data;
          res.field_first  = ({1'b0, bytes_left_r} == prefix_val_r);
          res.field_last   = (bytes_left_r <= 31'd1);
          res.field_length = prefix_val_r[30:0];
          if (bytes_left_r != 31'd0) begin
            bytes_left_nxt = bl_dec;
          end
          if (bytes_left_r <= 31'd1) begin
            phase_nxt = rfd_pkg::PH_ID;
          end
        end
      end
      rfd_pkg::PH_SKIP: begin
        if (in_last) begin
          phase_nxt = rfd_pkg::PH_WAIT;
        end
      end
      default: begin
        // waiting for the begin marker
        cur_field_nxt  = '0;
        bytes_left_nxt = '0;
        prefix_idx_nxt = '0;
        prefix_val_nxt = '0;
        total_nxt      = '0;
        if (in_last) begin
          fin      = 1'b1;
          fin_code = rfd_pkg::ERR_EMPTY;
        end else if (in_data == cfg.begin_marker) begin
          phase_nxt = rfd_pkg::PH_FIRST;
        end else begin
          phase_nxt = rfd_pkg::PH_BADBEGIN;
        end
      end
    endcase

    if (do_take) begin
      if (!id_defined) begin
        fin = 1'b1;
        if (in_data == cfg.end_marker) begin
          fin_kind = rfd_pkg::KIND_OK;
        end else begin
          fin_code = rfd_pkg::ERR_BAD_LEN;
        end
      end else if (len_code == rfd_pkg::LEN_INVALID) begin
        fin      = 1'b1;
        fin_code = rfd_pkg::ERR_BAD_LEN;
      end else if (in_last) begin
        fin      = 1'b1;
        fin_code = rfd_pkg::ERR_TRUNC;
      end else begin
        cur_field_nxt = in_data[3:0];
        if (len_code == rfd_pkg::LEN_VARIABLE) begin
          prefix_idx_nxt = '0;
          prefix_val_nxt = '0;
          phase_nxt      = rfd_pkg::PH_PREFIX;
        end else if (fix_over) begin
          fin      = 1'b1;
          fin_code = rfd_pkg::ERR_TOO_LONG;
        end else begin
          prefix_val_nxt = {24'b0, len_code};
          bytes_left_nxt = {23'b0, len_code};
          total_nxt      = fix_sum[TW-1:0];
          phase_nxt      = rfd_pkg::PH_PAYLOAD;
        end
      end
    end

    if (fin) begin
      res_valid      = 1'b1;
      res            = '0;
      res.kind       = fin_kind;
      res.error_code = fin_code;
      phase_nxt      = in_last ? rfd_pkg::PH_WAIT : rfd_pkg::PH_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rfd_pkg::PH_WAIT;
      cur_field_r  <= '0;
      bytes_left_r <= '0;
      prefix_idx_r <= '0;
      prefix_val_r <= '0;
      total_r      <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      cur_field_r  <= cur_field_nxt;
      bytes_left_r <= bytes_left_nxt;
      prefix_idx_r <= prefix_idx_nxt;
      prefix_val_r <= prefix_val_nxt;
      total_r      <= total_nxt;
    end
  end

endmodule

`default_nettype wire

[src/rfd_out_buf.sv]
`default_nettype none

module rfd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rfd_pkg::result_t  din,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rfd_pkg::result_t       dout
);

  rfd_pkg::result_t slot0_r, slot0_nxt;
  rfd_pkg::result_t slot1_r, slot1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign dout      = slot0_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (pop) begin
      slot0_nxt = slot1_r;
    end
    if (push) begin
      if ((cnt_r == 2'd0) || (pop && (cnt_r == 2'd1))) begin
        slot0_nxt = din;
      end else begin
        slot1_nxt = din;
      end
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("word pushed into full output buffer");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("output buffer count not reduced on pop");

  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && push && (cnt_r == 2'd0)) |=> (dout == $past(din)))
    else $error("word pushed into empty buffer not at head");

endmodule

`default_nettype wire
